[rtl/core/dedq_pkg.sv]
// shared types and constants for the double-ended queue core
package dedq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                     mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        t_status                   status;
        logic [OCC_W-1:0]          occupancy;
    } t_out_word;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic shift_right;   // push front: every cell takes its left neighbor
        logic shift_left;    // pop front: every cell takes its right neighbor
        logic load_back;     // push back: the first free cell takes the word
    } t_cell_ctl;

endpackage

[rtl/core/double_ended_queue_core.sv]
// top level of the double-ended queue: cell row, count register and result register
//
//  channel | signals                          | payload
//  --------+----------------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready          | i_in_word  (mode, value)
//  out     | o_out_valid / i_out_ready        | o_out_word (popped_value, status, occupancy)
//
// one word per cycle unless output stalls; each result registers the cycle after acceptance
// front entry sits in cell 0; push front and pop front shift the whole row by one cell
// the back entry is the cell at index count-1, picked by an or-tree over the cell taps
// reset clears the count and the output valid; cell contents need no reset
// a held result stalls input only when the output side is not taking it
module double_ended_queue_core #(
    parameter int DEPTH = dedq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dedq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dedq_pkg::t_out_word o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    dedq_pkg::t_out_word r_out;
    dedq_pkg::t_out_word n_out;

    logic                accept;
    logic                full;
    logic                empty;
    dedq_pkg::t_cell_ctl ctl;
    logic signed [dedq_pkg::VALUE_W-1:0] back_value;

    logic signed [dedq_pkg::VALUE_W-1:0] w_data [DEPTH];
    logic signed [dedq_pkg::VALUE_W-1:0] w_tap  [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == FULL_COUNT);
    assign empty      = (r_count == '0);

    always_comb begin
        ctl = '0;
        if (accept) begin
            unique case (i_in_word.mode)
                dedq_pkg::MODE_PUSH_FRONT: ctl.shift_right = !full;
                dedq_pkg::MODE_PUSH_BACK:  ctl.load_back   = !full;
                dedq_pkg::MODE_POP_FRONT:  ctl.shift_left  = !empty;
                dedq_pkg::MODE_POP_BACK:   ctl = '0;
                default:                   ctl = '0;
            endcase
        end
    end

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            logic signed [dedq_pkg::VALUE_W-1:0] left;
            logic signed [dedq_pkg::VALUE_W-1:0] right;

            if (k == 0) begin : g_first
                assign left = i_in_word.value;
            end else begin : g_mid_l
                assign left = w_data[k-1];
            end

            // last cell just keeps its word on a front pop; it is past the back then
            if (k == DEPTH - 1) begin : g_last
                assign right = w_data[k];
            end else begin : g_mid_r
                assign right = w_data[k+1];
            end

            dedq_cell #(
                .IDX (k),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_count      (r_count),
                .i_push_value (i_in_word.value),
                .i_left       (left),
                .i_right      (right),
                .o_data       (w_data[k]),
                .o_tap        (w_tap[k])
            );
        end
    endgenerate

    always_comb begin
        back_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_value = back_value | w_tap[k];
        end
    end

    always_comb begin
        n_count      = r_count;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid         = 1'b1;
            n_out.popped_value  = '0;
            n_out.status        = dedq_pkg::ST_OK;
            unique case (i_in_word.mode)
                dedq_pkg::MODE_PUSH_FRONT,
                dedq_pkg::MODE_PUSH_BACK: begin
                    if (full) begin
                        n_out.status = dedq_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                dedq_pkg::MODE_POP_FRONT: begin
                    if (empty) begin
                        n_out.status = dedq_pkg::ST_EMPTY;
                    end else begin
                        n_out.popped_value = w_data[0];
                        n_count            = r_count - CW'(1);
                    end
                end
                dedq_pkg::MODE_POP_BACK: begin
                    if (empty) begin
                        n_out.status = dedq_pkg::ST_EMPTY;
                    end else begin
                        n_out.popped_value = back_value;
                        n_count            = r_count - CW'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_out.occupancy = dedq_pkg::OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[rtl/core/dedq_cell.sv]
// one storage cell of the deque row: holds a word and trades it with its neighbors
module dedq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                 i_clk,
    input  dedq_pkg::t_cell_ctl                  i_ctl,
    input  logic [CW-1:0]                        i_count,
    input  logic signed [dedq_pkg::VALUE_W-1:0]  i_push_value,
    input  logic signed [dedq_pkg::VALUE_W-1:0]  i_left,
    input  logic signed [dedq_pkg::VALUE_W-1:0]  i_right,
    output logic signed [dedq_pkg::VALUE_W-1:0]  o_data,
    output logic signed [dedq_pkg::VALUE_W-1:0]  o_tap
);

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

    logic signed [dedq_pkg::VALUE_W-1:0] r_data;
    logic signed [dedq_pkg::VALUE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.shift_right) begin
            n_data = i_left;
        end else if (i_ctl.shift_left) begin
            n_data = i_right;
        end else if (i_ctl.load_back && (i_count == POS)) begin
            n_data = i_push_value;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // this cell holds the back word when it is the last occupied one
    assign o_tap  = (i_count == POS_NEXT) ? r_data : '0;

endmodule
